@@ design/ipv4icf_pkg.sv @@
// ----------------------------------------------------------------------------
// IPv4 ingress classifier package
// Shared types, codes and constants for the IPv4 classify and forward block.
// ----------------------------------------------------------------------------
package ipv4icf_pkg;

  localparam int NUM_IFACES_DEF = 4;

  localparam logic [31:0] ALL_ONES       = 32'hFFFF_FFFF;
  localparam logic [15:0] DHCP_SERVER    = 16'd67;
  localparam logic [3:0]  IP_VERSION4    = 4'd4;
  localparam logic [3:0]  BASE_HDR_WORDS = 4'd5;
  localparam logic [15:0] FRAG_MASK      = 16'h3FFF;
  localparam logic [3:0]  MCAST_PREFIX   = 4'hE;
  localparam logic [16:0] TTL_CHK_INC    = 17'h00100;

  localparam logic [7:0] PROTO_ICMP = 8'd1;
  localparam logic [7:0] PROTO_TCP  = 8'd6;
  localparam logic [7:0] PROTO_UDP  = 8'd17;

  // Configuration register indexes.
  localparam logic [2:0] CFG_IFACE0        = 3'd0;
  localparam logic [2:0] CFG_IFACE_COUNT   = 3'd4;
  localparam logic [2:0] CFG_DEFAULT_IFACE = 3'd5;

  localparam logic [2:0] IFACE_COUNT_RST   = 3'd0;
  localparam logic [2:0] DEFAULT_IFACE_RST = 3'd4;

  typedef enum logic [3:0] {
    ACT_UDP         = 4'd0,
    ACT_TCP         = 4'd1,
    ACT_ICMP        = 4'd2,
    ACT_BADVER      = 4'd3,
    ACT_SHORT       = 4'd4,
    ACT_FRAG        = 4'd5,
    ACT_OPTIONS     = 4'd6,
    ACT_UNREACH     = 4'd7,
    ACT_UNSUPPORTED = 4'd8,
    ACT_FORWARD     = 4'd9,
    ACT_BCAST       = 4'd10,
    ACT_NOROUTE     = 4'd11,
    ACT_SAMEIF      = 4'd12,
    ACT_TTL_ICMP    = 4'd13,
    ACT_TTL_SILENT  = 4'd14
  } action_t;

  typedef struct packed {
    logic [3:0]  version;
    logic [3:0]  header_words;
    logic [15:0] frame_len;
    logic [7:0]  protocol;
    logic [7:0]  ttl;
    logic [15:0] checksum;
    logic [15:0] frag_field;
    logic [31:0] dest_addr;
    logic [15:0] udp_src_port;
    logic [1:0]  in_iface;
  } hdr_t;

  typedef struct packed {
    action_t     action;
    logic [1:0]  out_iface;
    logic [7:0]  new_ttl;
    logic [15:0] new_checksum;
  } res_t;

  // Per-interface compare results.
  typedef struct packed {
    logic local_hit;
    logic exact_hit;
    logic masked_hit;
  } lane_flags_t;

endpackage

@@ design/ipv4icf_lane.sv @@
// ----------------------------------------------------------------------------
// IPv4 ingress classifier interface lane
// Compares one destination address against one interface address and mask.
// ----------------------------------------------------------------------------
module ipv4icf_lane (
  input  logic [63:0]              iface,
  input  logic [31:0]              dest_addr,
  output ipv4icf_pkg::lane_flags_t flags
);

  logic [31:0] addr;
  logic [31:0] mask;
  logic        dest_bcast;
  logic        net_match;

  assign addr = iface[63:32];
  assign mask = iface[31:0];

  assign dest_bcast = (dest_addr == ipv4icf_pkg::ALL_ONES) ||
                      ((dest_addr | mask) == ipv4icf_pkg::ALL_ONES);
  assign net_match  = (dest_addr & mask) == (addr & mask);

  // An unnumbered interface accepts everything as local.
  assign flags.local_hit  = (addr == 32'd0) || (dest_addr == addr) ||
                            (dest_bcast && net_match);
  assign flags.exact_hit  = dest_addr == addr;
  assign flags.masked_hit = net_match;

endmodule

@@ design/ipv4icf_decide.sv @@
// ----------------------------------------------------------------------------
// IPv4 ingress classifier decision logic
// Classifies one header and computes the forwarding result in one pass.
// ----------------------------------------------------------------------------
module ipv4icf_decide #(
  parameter int NUM_IFACES = ipv4icf_pkg::NUM_IFACES_DEF
) (
  input  ipv4icf_pkg::hdr_t              hdr,
  input  logic [NUM_IFACES-1:0][63:0]    iface,
  input  logic [2:0]                     iface_count,
  input  logic [2:0]                     default_iface,
  output ipv4icf_pkg::res_t              res
);

  ipv4icf_pkg::lane_flags_t [NUM_IFACES-1:0] flags;
  logic [NUM_IFACES-1:0] lane_en;
  logic [2:0]            searched;
  logic [31:0]           in_mask;
  logic                  any_local;
  logic                  is_local;
  logic                  in_bcast;
  logic                  is_mcast;
  logic                  ex_hit;
  logic [1:0]            ex_idx;
  logic                  mk_hit;
  logic [1:0]            mk_idx;
  logic                  rt_hit;
  logic [1:0]            rt_idx;
  logic [7:0]            ttl_dec;
  logic [16:0]           chk_sum;
  logic [16:0]           chk_fold;

  for (genvar g = 0; g < NUM_IFACES; g++) begin : g_lane
    ipv4icf_lane u_lane (
      .iface     (iface[g]),
      .dest_addr (hdr.dest_addr),
      .flags     (flags[g])
    );
  end

  assign searched = (iface_count > 3'(NUM_IFACES)) ? 3'(NUM_IFACES) : iface_count;

  always_comb begin
    lane_en   = '0;
    in_mask   = 32'd0;
    any_local = 1'b0;
    ex_hit    = 1'b0;
    ex_idx    = 2'd0;
    mk_hit    = 1'b0;
    mk_idx    = 2'd0;
    // Walking down from the top leaves the lowest matching index.
    for (int i = NUM_IFACES - 1; i >= 0; i--) begin
      lane_en[i] = 3'(i) < searched;
      if (hdr.in_iface == 2'(i)) begin
        in_mask = iface[i][31:0];
      end
      if (lane_en[i] && flags[i].local_hit) begin
        any_local = 1'b1;
      end
      if (lane_en[i] && flags[i].exact_hit) begin
        ex_hit = 1'b1;
        ex_idx = 2'(i);
      end
      if (lane_en[i] && flags[i].masked_hit) begin
        mk_hit = 1'b1;
        mk_idx = 2'(i);
      end
    end
  end

  always_comb begin
    // A limited broadcast is local as soon as one interface is searched.
    is_local = any_local ||
               ((hdr.dest_addr == ipv4icf_pkg::ALL_ONES) && (searched != 3'd0)) ||
               ((hdr.protocol == ipv4icf_pkg::PROTO_UDP) &&
                (hdr.udp_src_port == ipv4icf_pkg::DHCP_SERVER));
    in_bcast = (hdr.dest_addr == ipv4icf_pkg::ALL_ONES) ||
               ((hdr.dest_addr | in_mask) == ipv4icf_pkg::ALL_ONES);
    is_mcast = hdr.dest_addr[31:28] == ipv4icf_pkg::MCAST_PREFIX;

    if (ex_hit) begin
      rt_hit = 1'b1;
      rt_idx = ex_idx;
    end else if (mk_hit) begin
      rt_hit = 1'b1;
      rt_idx = mk_idx;
    end else begin
      rt_hit = default_iface < 3'(NUM_IFACES);
      rt_idx = default_iface[1:0];
    end

    // Decrementing the TTL byte in the high half of its word adds 0x0100 to
    // the one's-complement checksum, with end-around carry.
    ttl_dec  = hdr.ttl - 8'd1;
    chk_sum  = {1'b0, hdr.checksum} + ipv4icf_pkg::TTL_CHK_INC;
    chk_fold = chk_sum + {16'd0, chk_sum[16]};
  end

  always_comb begin
    res = '0;
    if (hdr.version != ipv4icf_pkg::IP_VERSION4) begin
      res.action = ipv4icf_pkg::ACT_BADVER;
    end else if ({10'd0, hdr.header_words, 2'b00} > hdr.frame_len) begin
      res.action = ipv4icf_pkg::ACT_SHORT;
    end else if (is_local) begin
      if ((hdr.frag_field & ipv4icf_pkg::FRAG_MASK) != 16'd0) begin
        res.action = ipv4icf_pkg::ACT_FRAG;
      end else if (hdr.header_words > ipv4icf_pkg::BASE_HDR_WORDS) begin
        res.action = ipv4icf_pkg::ACT_OPTIONS;
      end else if (hdr.protocol == ipv4icf_pkg::PROTO_UDP) begin
        res.action = ipv4icf_pkg::ACT_UDP;
      end else if (hdr.protocol == ipv4icf_pkg::PROTO_TCP) begin
        res.action = ipv4icf_pkg::ACT_TCP;
      end else if (hdr.protocol == ipv4icf_pkg::PROTO_ICMP) begin
        res.action = ipv4icf_pkg::ACT_ICMP;
      end else if (!in_bcast && !is_mcast) begin
        res.action = ipv4icf_pkg::ACT_UNREACH;
      end else begin
        res.action = ipv4icf_pkg::ACT_UNSUPPORTED;
      end
    end else if (in_bcast) begin
      res.action = ipv4icf_pkg::ACT_BCAST;
    end else if (!rt_hit) begin
      res.action = ipv4icf_pkg::ACT_NOROUTE;
    end else if (rt_idx == hdr.in_iface) begin
      res.action = ipv4icf_pkg::ACT_SAMEIF;
    end else if (ttl_dec == 8'd0) begin
      res.action = (hdr.protocol == ipv4icf_pkg::PROTO_ICMP) ?
                   ipv4icf_pkg::ACT_TTL_SILENT : ipv4icf_pkg::ACT_TTL_ICMP;
    end else begin
      res.action       = ipv4icf_pkg::ACT_FORWARD;
      res.out_iface    = rt_idx;
      res.new_ttl      = ttl_dec;
      res.new_checksum = chk_fold[15:0];
    end
  end

endmodule

@@ design/ipv4_ingress_classify_forward_unit.sv @@
// ----------------------------------------------------------------------------
// IPv4 ingress classify and forward unit
// Per-header receive classification and forwarding decision.
// ----------------------------------------------------------------------------
// One parsed IPv4 header enters per cycle while in_stall is low and gives
// exactly one result item, which reaches the outputs as follows:
// the header is captured in an input register, classified by one pass of
// logic with the interface compares done in parallel lanes, and the result is
// held in an output register. The input side keeps taking items while a
// result waits, and only stalls when both registers are full and the output
// is stalled. Interface registers are to be written through the cfg port only
// while no item is in flight; the block itself does not enforce this.
module ipv4_ingress_classify_forward_unit #(
  parameter int NUM_IFACES = ipv4icf_pkg::NUM_IFACES_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [63:0] cfg_wdata,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [3:0]  in_version,
  input  logic [3:0]  in_header_words,
  input  logic [15:0] in_frame_len,
  input  logic [7:0]  in_protocol,
  input  logic [7:0]  in_ttl,
  input  logic [15:0] in_checksum,
  input  logic [15:0] in_frag_field,
  input  logic [31:0] in_dest_addr,
  input  logic [15:0] in_udp_src_port,
  input  logic [1:0]  in_in_iface,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [3:0]  out_action,
  output logic [1:0]  out_out_iface,
  output logic [7:0]  out_new_ttl,
  output logic [15:0] out_new_checksum
);

  logic [NUM_IFACES-1:0][63:0] iface_r;
  logic [2:0]                  iface_count_r;
  logic [2:0]                  default_iface_r;
  ipv4icf_pkg::hdr_t           hdr_r;
  logic                        hdr_vld_r;
  ipv4icf_pkg::res_t           res_nxt;
  ipv4icf_pkg::res_t           res_r;
  logic                        out_vld_r;
  logic                        advance;
  logic                        in_take;

  assign advance  = !out_vld_r || !out_stall;
  assign in_stall = hdr_vld_r && !advance;
  assign in_take  = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      iface_r         <= '0;
      iface_count_r   <= ipv4icf_pkg::IFACE_COUNT_RST;
      default_iface_r <= ipv4icf_pkg::DEFAULT_IFACE_RST;
    end else if (cfg_we) begin
      for (int i = 0; i < NUM_IFACES; i++) begin
        if (cfg_index == ipv4icf_pkg::CFG_IFACE0 + 3'(i)) begin
          iface_r[i] <= cfg_wdata;
        end
      end
      if (cfg_index == ipv4icf_pkg::CFG_IFACE_COUNT) begin
        iface_count_r <= cfg_wdata[2:0];
      end
      if (cfg_index == ipv4icf_pkg::CFG_DEFAULT_IFACE) begin
        default_iface_r <= cfg_wdata[2:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hdr_vld_r <= 1'b0;
      out_vld_r <= 1'b0;
    end else begin
      if (!hdr_vld_r || advance) begin
        hdr_vld_r <= in_valid;
      end
      if (advance) begin
        out_vld_r <= hdr_vld_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      hdr_r <= '{version:      in_version,
                 header_words: in_header_words,
                 frame_len:    in_frame_len,
                 protocol:     in_protocol,
                 ttl:          in_ttl,
                 checksum:     in_checksum,
                 frag_field:   in_frag_field,
                 dest_addr:    in_dest_addr,
                 udp_src_port: in_udp_src_port,
                 in_iface:     in_in_iface};
    end
    if (advance && hdr_vld_r) begin
      res_r <= res_nxt;
    end
  end

  ipv4icf_decide #(
    .NUM_IFACES (NUM_IFACES)
  ) u_decide (
    .hdr           (hdr_r),
    .iface         (iface_r),
    .iface_count   (iface_count_r),
    .default_iface (default_iface_r),
    .res           (res_nxt)
  );

  assign out_valid        = out_vld_r;
  assign out_action       = res_r.action;
  assign out_out_iface    = res_r.out_iface;
  assign out_new_ttl      = res_r.new_ttl;
  assign out_new_checksum = res_r.new_checksum;

endmodule
